FILE: hdl/drc_pkg.sv
// drc_pkg: flit layout, port codes, channel beat types and register indexes
// for the deflection router cycle block
// no dependencies
`default_nettype none

package drc_pkg;

  localparam int PortCount = 4;
  localparam int FlitWidth = 56;
  localparam int CoordWidth = 4;
  localparam int IdWidth = 15;
  localparam int TimeWidth = 24;
  localparam int CfgIndexWidth = 1;
  localparam int CfgDataWidth = CoordWidth;

  typedef logic [FlitWidth-1:0] flit_word_t;
  typedef logic [CoordWidth-1:0] coord_t;
  typedef logic [PortCount-1:0] port_mask_t;

  // packed field view of a flit word, msb first
  typedef struct packed {
    logic [TimeWidth-1:0] inj_time;
    logic [IdWidth-1:0] id;
    coord_t src_y;
    coord_t src_x;
    coord_t dest_y;
    coord_t dest_x;
    logic valid;
  } flit_t;

  typedef enum logic [1:0] {
    PORT_E = 2'd0,
    PORT_W = 2'd1,
    PORT_N = 2'd2,
    PORT_S = 2'd3
  } port_t;

  localparam logic [CfgIndexWidth-1:0] REG_NODE_X = 1'd0;
  localparam logic [CfgIndexWidth-1:0] REG_NODE_Y = 1'd1;

  typedef struct packed {
    flit_word_t east_in;
    flit_word_t west_in;
    flit_word_t north_in;
    flit_word_t south_in;
    flit_word_t new_inject;
  } in_item_t;

  typedef struct packed {
    flit_word_t east_out;
    flit_word_t west_out;
    flit_word_t north_out;
    flit_word_t south_out;
    flit_word_t ejected;
    logic inject_taken;
  } out_item_t;

  // what one lane finds about its flit
  typedef struct packed {
    logic valid;
    logic here;
    port_t prod;
  } lane_info_t;

endpackage

`default_nettype wire

FILE: hdl/drc_if.sv
// drc_in_if / drc_out_if: valid-ready channels carrying one router beat
// depends on drc_pkg
`default_nettype none

interface drc_in_if;
  logic valid;
  logic ready;
  drc_pkg::in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface drc_out_if;
  logic valid;
  logic ready;
  drc_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/deflection_router_cycle.sv
// deflection_router_cycle: top level, ejection/injection stage, held inject
// register and output register; depends on drc_pkg, drc_if, drc_lane, drc_merge
//
//   channel   dir  beat        contents
//   flits     in   in_item_t   four port flits and a new inject flit
//   routed    out  out_item_t  four port flits, ejected flit, inject_taken
//   cfg_*     in   write       node_x (index 0), node_y (index 1)
//
// one beat per clock while the output is not stalled. from accept to output:
// stage 1 ejects, injects and finds each slot's productive port, stage 2
// picks the oldest flit and deflects the rest. the held inject register is
// updated in stage 1 on the accepting edge.
// rst clears the held inject flit, node coordinates and both valid flags.
// a stalled output holds its beat; stage 1 keeps accepting while it has room.
`default_nettype none

module deflection_router_cycle (
  input  logic                              clk,
  input  logic                              rst,
  drc_in_if.sink                            flits,
  drc_out_if.source                         routed,
  input  logic                              cfg_we,
  input  logic [drc_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [drc_pkg::CfgDataWidth-1:0]  cfg_data
);
  import drc_pkg::*;

  coord_t     node_x, node_y;
  flit_word_t held_inject, held_cur, held_next;

  flit_word_t raw [PortCount];
  lane_info_t info [PortCount];
  lane_info_t held_info;

  flit_word_t slot_next [PortCount];
  port_mask_t ok_next;
  port_t      prod_next [PortCount];
  flit_word_t ej_next;
  logic       taken_next;
  logic       ej_found;

  logic       s1_valid;
  flit_word_t s1_slot [PortCount];
  port_mask_t s1_ok;
  port_t      s1_prod [PortCount];
  flit_word_t s1_ej;
  logic       s1_taken;

  out_item_t  merged;
  logic       s1_ready, in_accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_x <= '0;
      node_y <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NODE_X: node_x <= cfg_data;
        REG_NODE_Y: node_y <= cfg_data;
        default: ;
      endcase
    end
  end

  assign raw[PORT_E] = flits.data.east_in;
  assign raw[PORT_W] = flits.data.west_in;
  assign raw[PORT_N] = flits.data.north_in;
  assign raw[PORT_S] = flits.data.south_in;

  // a valid new inject flit replaces the held one before injection
  assign held_cur = flits.data.new_inject[0] ? flits.data.new_inject : held_inject;

  for (genvar g = 0; g < PortCount; g++) begin : g_lane
    drc_lane u_lane (
      .flit   (raw[g]),
      .node_x (node_x),
      .node_y (node_y),
      .info   (info[g])
    );
  end

  drc_lane u_held_lane (
    .flit   (held_cur),
    .node_x (node_x),
    .node_y (node_y),
    .info   (held_info)
  );

  always_comb begin
    ej_found = 1'b0;
    ej_next = '0;
    taken_next = 1'b0;
    for (int i = 0; i < PortCount; i++) begin
      slot_next[i] = raw[i];
      prod_next[i] = info[i].prod;
      ok_next[i] = info[i].valid;
      if (!ej_found && info[i].here) begin
        ej_found = 1'b1;
        ej_next = raw[i];
        ok_next[i] = 1'b0;
      end
    end
    for (int i = 0; i < PortCount; i++) begin
      if (held_info.valid && !taken_next && !ok_next[i]) begin
        slot_next[i] = held_cur;
        prod_next[i] = held_info.prod;
        ok_next[i] = 1'b1;
        taken_next = 1'b1;
      end
    end
    held_next = taken_next ? '0 : held_cur;
  end

  assign s1_ready = !routed.valid || routed.ready;
  assign flits.ready = !s1_valid || s1_ready;
  assign in_accept = flits.valid && flits.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_inject <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (in_accept) held_inject <= held_next;
      if (flits.ready) s1_valid <= flits.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_slot <= slot_next;
      s1_ok <= ok_next;
      s1_prod <= prod_next;
      s1_ej <= ej_next;
      s1_taken <= taken_next;
    end
  end

  drc_merge u_merge (
    .slot      (s1_slot),
    .slot_ok   (s1_ok),
    .slot_prod (s1_prod),
    .ej        (s1_ej),
    .taken     (s1_taken),
    .result    (merged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      routed.valid <= 1'b0;
    end else if (s1_ready) begin
      routed.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) routed.data <= merged;
  end

`ifndef SYNTHESIS
  a_held_cleared: assert property (@(posedge clk) disable iff (rst)
    (in_accept && taken_next) |=> !held_inject[0])
    else $error("held inject flit not cleared after injection");

  a_eject_local: assert property (@(posedge clk) disable iff (rst)
    (routed.valid && routed.data.ejected[0]) |->
      (routed.data.ejected[4:1] == node_x && routed.data.ejected[8:5] == node_y))
    else $error("ejected flit not addressed to this node");

  a_taken_routed: assert property (@(posedge clk) disable iff (rst)
    (routed.valid && routed.data.inject_taken) |->
      (routed.data.east_out[0] || routed.data.west_out[0] ||
       routed.data.north_out[0] || routed.data.south_out[0]))
    else $error("inject taken but no flit leaves");

  a_held_kept: assert property (@(posedge clk) disable iff (rst)
    (in_accept && held_cur[0] && !taken_next) |=> held_inject[0])
    else $error("held inject flit lost while ports full");
`endif

endmodule

`default_nettype wire

FILE: hdl/drc_lane.sv
// drc_lane: per-flit core, checks validity, local address match and the
// productive output direction for one flit; depends on drc_pkg
`default_nettype none

module drc_lane (
  input  drc_pkg::flit_word_t flit,
  input  drc_pkg::coord_t     node_x,
  input  drc_pkg::coord_t     node_y,
  output drc_pkg::lane_info_t info
);
  import drc_pkg::*;

  flit_t f;
  logic  odd;
  port_t vert;

  assign f = flit_t'(flit);
  assign odd = f.id[0];
  assign vert = (f.dest_y > node_y) ? PORT_S : PORT_N;

  always_comb begin
    info.valid = f.valid;
    info.here = f.valid && (f.dest_x == node_x) && (f.dest_y == node_y);
    if (f.dest_x == node_x) begin
      // addressed here but not ejected falls back to east
      if (f.dest_y > node_y) info.prod = PORT_S;
      else if (f.dest_y < node_y) info.prod = PORT_N;
      else info.prod = PORT_E;
    end else if (f.dest_y == node_y) begin
      info.prod = (f.dest_x > node_x) ? PORT_E : PORT_W;
    end else if (f.dest_x > node_x) begin
      info.prod = odd ? PORT_E : vert;
    end else begin
      info.prod = odd ? PORT_W : vert;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/drc_merge.sv
// drc_merge: merging stage, picks the oldest slot, routes it productively and
// deflects the rest to the first free outputs; depends on drc_pkg
`default_nettype none

module drc_merge (
  input  drc_pkg::flit_word_t slot [drc_pkg::PortCount],
  input  drc_pkg::port_mask_t slot_ok,
  input  drc_pkg::port_t      slot_prod [drc_pkg::PortCount],
  input  drc_pkg::flit_word_t ej,
  input  logic                taken,
  output drc_pkg::out_item_t  result
);
  import drc_pkg::*;

  flit_word_t outs [PortCount];
  port_mask_t occ;
  logic       placed;
  logic [1:0] best_lo, best_hi, best;
  logic       any;

  function automatic logic older(input flit_word_t a, input flit_word_t b);
    flit_t fa, fb;
    fa = flit_t'(a);
    fb = flit_t'(b);
    return fb.inj_time < fa.inj_time;
  endfunction

  // two-level tree, the lower index keeps ties
  always_comb begin
    if (!slot_ok[1]) best_lo = 2'd0;
    else if (!slot_ok[0]) best_lo = 2'd1;
    else best_lo = older(slot[0], slot[1]) ? 2'd1 : 2'd0;
    if (!slot_ok[3]) best_hi = 2'd2;
    else if (!slot_ok[2]) best_hi = 2'd3;
    else best_hi = older(slot[2], slot[3]) ? 2'd3 : 2'd2;
    if (!(slot_ok[3] || slot_ok[2])) best = best_lo;
    else if (!(slot_ok[1] || slot_ok[0])) best = best_hi;
    else best = older(slot[best_lo], slot[best_hi]) ? best_hi : best_lo;
    any = |slot_ok;
  end

  always_comb begin
    occ = '0;
    placed = 1'b0;
    for (int j = 0; j < PortCount; j++) outs[j] = '0;
    if (any) begin
      outs[slot_prod[best]] = slot[best];
      occ[slot_prod[best]] = 1'b1;
    end
    for (int i = 0; i < PortCount; i++) begin
      if (slot_ok[i] && !(any && (best == i[1:0]))) begin
        placed = 1'b0;
        for (int j = 0; j < PortCount; j++) begin
          if (!placed && !occ[j]) begin
            outs[j] = slot[i];
            occ[j] = 1'b1;
            placed = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    result.east_out = outs[PORT_E];
    result.west_out = outs[PORT_W];
    result.north_out = outs[PORT_N];
    result.south_out = outs[PORT_S];
    result.ejected = ej;
    result.inject_taken = taken;
  end

endmodule

`default_nettype wire
